### src/srde_pkg.sv
// Shared types and constants for the signed radix digit emitter.
package srde_pkg;

    localparam int MAX_BASE       = 16;
    localparam int MAX_DIGITS     = 32;
    localparam int VALUE_W        = 32;
    localparam int CHAR_W         = 8;
    localparam int SIZE_W         = 5;
    localparam int DIGIT_W        = 4;
    localparam int ALPHA_W        = 64;
    localparam int CFG_IDX_W      = 2;
    localparam int PTR_W          = $clog2(MAX_DIGITS);
    localparam int CNT_W          = PTR_W + 1;
    localparam int BITS_PER_CYCLE = 8;
    localparam int DIV_CYCLES     = VALUE_W / BITS_PER_CYCLE;
    localparam int STEP_W         = $clog2(DIV_CYCLES);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SIZE_W-1:0] MIN_SIZE   = 5'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_HIGH = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_SIGN,
        S_DIGITS
    } t_state;

    typedef struct packed {
        logic load;
        logic div;
        logic emit_sign;
        logic emit_digit;
    } t_dp_cmd;

    typedef struct packed {
        logic alpha_ok;
        logic div_last;
        logic quo_zero;
        logic neg;
        logic out_free;
        logic digit_last;
    } t_dp_stat;

endpackage

### src/srde_ctrl.sv
// Controller state machine: sequences check, division and character output.
module srde_ctrl
    import srde_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_stat.alpha_ok ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (i_stat.div_last && i_stat.quo_zero) n_state = S_SIGN;
            end
            S_SIGN: begin
                if (!i_stat.neg || i_stat.out_free) n_state = S_DIGITS;
            end
            S_DIGITS: begin
                if (i_stat.out_free && i_stat.digit_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall       = 1'b1;
        o_cmd            = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_CHECK: begin
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
            end
            S_SIGN: begin
                o_cmd.emit_sign = i_stat.neg && i_stat.out_free;
            end
            S_DIGITS: begin
                o_cmd.emit_digit = i_stat.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

### src/srde_dp.sv
// Datapath: configuration registers, alphabet check, divider, digit stack, output register.
module srde_dp
    import srde_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ALPHA_W-1:0]          i_cfg_data,
    input  logic signed [VALUE_W-1:0]   i_value,
    input  logic                        i_out_stall,
    input  t_dp_cmd                     i_cmd,
    output t_dp_stat                    o_stat,
    output logic                        o_out_valid,
    output logic [CHAR_W-1:0]           o_out_char,
    output logic                        o_last
);

    logic [SIZE_W-1:0]      r_base_size;
    logic [ALPHA_W-1:0]     r_alpha_low;
    logic [ALPHA_W-1:0]     r_alpha_high;

    logic [VALUE_W-1:0]     r_mag;
    logic [DIGIT_W-1:0]     r_rem;
    logic                   r_neg;
    logic [STEP_W-1:0]      r_step;
    logic [DIGIT_W-1:0]     r_dig [MAX_DIGITS];
    logic [CNT_W-1:0]       r_nd;
    logic                   r_out_valid;
    logic [CHAR_W-1:0]      r_out_char;
    logic                   r_last;

    logic [SIZE_W-1:0]      used_size;
    logic [2*ALPHA_W-1:0]   alphabet;
    logic                   alpha_ok;
    logic [VALUE_W-1:0]     n_mag;
    logic [DIGIT_W-1:0]     n_rem;
    logic [PTR_W-1:0]       rd_ptr;
    logic [DIGIT_W-1:0]     rd_digit;
    logic [VALUE_W-1:0]     raw;

    assign alphabet  = {r_alpha_high, r_alpha_low};
    assign used_size = (r_base_size > SIZE_W'(MAX_BASE)) ? SIZE_W'(MAX_BASE) : r_base_size;
    assign raw       = i_value;

    // alphabet validity: size, sign characters, duplicates among used positions
    always_comb begin
        logic [CHAR_W-1:0] ci;
        alpha_ok = (used_size >= MIN_SIZE);
        for (int i = 0; i < MAX_BASE; i++) begin
            ci = alphabet[i*CHAR_W +: CHAR_W];
            if (SIZE_W'(i) < used_size) begin
                if (ci == CHAR_MINUS || ci == CHAR_PLUS) alpha_ok = 1'b0;
                for (int j = i + 1; j < MAX_BASE; j++) begin
                    if (SIZE_W'(j) < used_size && alphabet[j*CHAR_W +: CHAR_W] == ci)
                        alpha_ok = 1'b0;
                end
            end
        end
    end

    // restoring division, BITS_PER_CYCLE quotient bits per cycle
    always_comb begin
        logic [SIZE_W-1:0] sh;
        logic [DIGIT_W-1:0] rem;
        logic [VALUE_W-1:0] mag;
        rem = r_rem;
        mag = r_mag;
        for (int k = 0; k < BITS_PER_CYCLE; k++) begin
            sh = {rem, mag[VALUE_W-1]};
            if (sh >= used_size) begin
                sh  = sh - used_size;
                mag = {mag[VALUE_W-2:0], 1'b1};
            end else begin
                mag = {mag[VALUE_W-2:0], 1'b0};
            end
            rem = sh[DIGIT_W-1:0];
        end
        n_mag = mag;
        n_rem = rem;
    end

    assign rd_ptr   = PTR_W'(r_nd - CNT_W'(1));
    assign rd_digit = r_dig[rd_ptr];

    assign o_stat.alpha_ok   = alpha_ok;
    assign o_stat.div_last   = (r_step == STEP_W'(DIV_CYCLES - 1));
    assign o_stat.quo_zero   = (n_mag == '0);
    assign o_stat.neg        = r_neg;
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;
    assign o_stat.digit_last = (r_nd == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_size  <= '0;
            r_alpha_low  <= '0;
            r_alpha_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BASE_SIZE:     r_base_size  <= i_cfg_data[SIZE_W-1:0];
                REG_ALPHABET_LOW:  r_alpha_low  <= i_cfg_data;
                REG_ALPHABET_HIGH: r_alpha_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_nd   <= '0;
        end else if (i_cmd.load) begin
            r_step <= '0;
            r_nd   <= '0;
        end else if (i_cmd.div) begin
            r_step <= r_step + STEP_W'(1);
            if (o_stat.div_last) r_nd <= r_nd + CNT_W'(1);
        end else if (i_cmd.emit_digit) begin
            r_nd <= r_nd - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= raw[VALUE_W-1];
            r_mag <= raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
            r_rem <= '0;
        end else if (i_cmd.div) begin
            r_mag <= n_mag;
            if (o_stat.div_last) begin
                r_dig[r_nd[PTR_W-1:0]] <= n_rem;
                r_rem                  <= '0;
            end else begin
                r_rem <= n_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_out_char <= CHAR_MINUS;
            r_last     <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_out_char <= alphabet[rd_digit*CHAR_W +: CHAR_W];
            r_last     <= (r_nd == CNT_W'(1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last      = r_last;

endmodule

### src/signed_radix_digit_emitter.sv
// Top level of the signed radix digit emitter.
// Prints one signed 32-bit value per input transfer as a run of characters in the
// configured base, most significant digit first, with a leading '-' for negative
// values and o_last on the final character. An invalid alphabet (size below 2,
// a repeated character, or '+' or '-' among the digits) yields no characters.
// One item is handled at a time: the alphabet check, then one division per digit in
// the shared divider (8 quotient bits per cycle), then the sign step (taken for
// positive values too), then the digits through the output register. The next
// input transfer is taken once the last character is loaded into the output
// register. An item with an invalid alphabet goes back to idle after the check.
module signed_radix_digit_emitter
    import srde_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ALPHA_W-1:0]          i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [VALUE_W-1:0]   i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [CHAR_W-1:0]           o_out_char,
    output logic                        o_last
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    srde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    srde_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_value     (i_value),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_char  (o_out_char),
        .o_last      (o_last)
    );

endmodule
